FILE: src/tsbr_pkg.sv
// Package for the transfer splitter: transaction types, queue entry type,
// state enums and fixed widths. No dependencies.
package tsbr_pkg;

   localparam int ADDR_W     = 48;
   localparam int WIDE_W     = 49;
   localparam int RANK_W     = 6;
   localparam int DIV_W      = ADDR_W + RANK_W;
   localparam int LIMIT_W    = ADDR_W + RANK_W + 1;
   localparam int STEP_W     = 3;
   localparam int QPTR_W     = 1;
   localparam int QDEPTH     = 2;
   localparam int QCNT_W     = 2;

   typedef struct packed {
      logic [ADDR_W-1:0] local_start;
      logic [ADDR_W-1:0] peer_base;
      logic [ADDR_W-1:0] global_offset;
      logic [ADDR_W-1:0] slice_size;
      logic [ADDR_W-1:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [WIDE_W-1:0] part_local_offset;
      logic [RANK_W-1:0] part_rank;
      logic [ADDR_W-1:0] part_size;
      logic [WIDE_W-1:0] part_remote_offset;
      logic              part_last;
      logic              part_error;
   } rsp_type;

   // One classified request, handed from front to back.
   typedef struct packed {
      logic [ADDR_W-1:0] loc;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] slice;
      logic [ADDR_W-1:0] amount;
      logic [RANK_W-1:0] rank;
      logic [ADDR_W-1:0] slice_ofs;
      logic              err;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef enum logic [2:0] {
      FRONT_IDLE,
      FRONT_CHECK,
      FRONT_GUARD,
      FRONT_DIVIDE,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage

FILE: src/tsbr_front.sv
// Front end: takes a transaction, checks the rank span, finds the first rank
// and offset within the slice by restoring division, and queues the job
// unless it has zero bytes. Depends on tsbr_pkg.
module tsbr_front #(
   parameter int MAX_RANKS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tsbr_pkg::req_type  req_item,
   input  tsbr_pkg::qstat_type q_stat,
   output logic               q_push,
   output tsbr_pkg::job_type  q_job
);

   tsbr_pkg::front_state_type state_ff, state_in;
   tsbr_pkg::req_type req_ff, req_in;
   logic [tsbr_pkg::WIDE_W-1:0]  last_byte_ff, last_byte_in;
   logic [tsbr_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [tsbr_pkg::ADDR_W-1:0]  rem_ff, rem_in;
   logic [tsbr_pkg::DIV_W-1:0]   div_ff, div_in;
   logic [tsbr_pkg::RANK_W-1:0]  quo_ff, quo_in;
   logic [tsbr_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                         err_ff, err_in;
   logic                         ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsbr_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff       <= req_in;
      last_byte_ff <= last_byte_in;
      limit_ff     <= limit_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      err_ff       <= err_in;
   end

   assign busy = (state_ff != tsbr_pkg::FRONT_IDLE);
   assign ge   = ({{tsbr_pkg::RANK_W{1'b0}}, rem_ff} >= div_ff);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      last_byte_in = last_byte_ff;
      limit_in     = limit_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      err_in       = err_ff;
      q_push       = 1'b0;

      q_job.loc       = req_ff.local_start;
      q_job.base      = req_ff.peer_base;
      q_job.slice     = req_ff.slice_size;
      q_job.amount    = req_ff.byte_count;
      q_job.rank      = quo_ff;
      q_job.slice_ofs = rem_ff;
      q_job.err       = err_ff;

      case (state_ff)
         tsbr_pkg::FRONT_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = tsbr_pkg::FRONT_CHECK;
            end
         end
         tsbr_pkg::FRONT_CHECK: begin
            last_byte_in = {1'b0, req_ff.global_offset} + {1'b0, req_ff.byte_count}
                           - tsbr_pkg::WIDE_W'(1);
            limit_in = tsbr_pkg::LIMIT_W'(req_ff.slice_size)
                       * tsbr_pkg::LIMIT_W'(MAX_RANKS);
            state_in = tsbr_pkg::FRONT_GUARD;
         end
         tsbr_pkg::FRONT_GUARD: begin
            if (req_ff.byte_count == '0) begin
               state_in = tsbr_pkg::FRONT_IDLE;
            end else if (req_ff.slice_size == '0 ||
                         tsbr_pkg::LIMIT_W'(last_byte_ff) >= limit_ff) begin
               err_in   = 1'b1;
               state_in = tsbr_pkg::FRONT_PUSH;
            end else begin
               err_in   = 1'b0;
               rem_in   = req_ff.global_offset;
               div_in   = {1'b0, req_ff.slice_size, {(tsbr_pkg::RANK_W-1){1'b0}}};
               quo_in   = '0;
               step_in  = tsbr_pkg::STEP_W'(tsbr_pkg::RANK_W - 1);
               state_in = tsbr_pkg::FRONT_DIVIDE;
            end
         end
         tsbr_pkg::FRONT_DIVIDE: begin
            if (ge) begin
               rem_in = rem_ff - div_ff[tsbr_pkg::ADDR_W-1:0];
            end
            quo_in = {quo_ff[tsbr_pkg::RANK_W-2:0], ge};
            div_in = div_ff >> 1;
            if (step_ff == '0) begin
               state_in = tsbr_pkg::FRONT_PUSH;
            end else begin
               step_in = step_ff - tsbr_pkg::STEP_W'(1);
            end
         end
         tsbr_pkg::FRONT_PUSH: begin
            if (!q_stat.full) begin
               q_push   = 1'b1;
               state_in = tsbr_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = tsbr_pkg::FRONT_IDLE;
         end
      endcase
   end

endmodule

FILE: src/tsbr_queue.sv
// Two-entry job queue between front and back end.
// Depends on tsbr_pkg.
module tsbr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tsbr_pkg::job_type   wr_job,
   input  logic                pop,
   output tsbr_pkg::job_type   rd_job,
   output tsbr_pkg::qstat_type stat
);

   tsbr_pkg::job_type mem_ff [tsbr_pkg::QDEPTH];
   logic [tsbr_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [tsbr_pkg::QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + tsbr_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + tsbr_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + tsbr_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - tsbr_pkg::QCNT_W'(1);
         end
      end
   end

   assign rd_job     = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == tsbr_pkg::QCNT_W'(tsbr_pkg::QDEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

FILE: src/tsbr_back.sv
// Back end: takes a queued job and emits one part per cycle, cut at slice
// boundaries, through a registered result port. Depends on tsbr_pkg.
module tsbr_back (
   input  logic                clock,
   input  logic                reset,
   input  tsbr_pkg::qstat_type q_stat,
   input  tsbr_pkg::job_type   q_job,
   output logic                q_pop,
   output logic                rsp_valid,
   output tsbr_pkg::rsp_type   rsp_part
);

   tsbr_pkg::back_state_type state_ff, state_in;
   logic [tsbr_pkg::WIDE_W-1:0] loc_ff, loc_in;
   logic [tsbr_pkg::ADDR_W-1:0] base_ff, base_in;
   logic [tsbr_pkg::ADDR_W-1:0] slice_ff, slice_in;
   logic [tsbr_pkg::ADDR_W-1:0] amount_ff, amount_in;
   logic [tsbr_pkg::ADDR_W-1:0] within_ff, within_in;
   logic [tsbr_pkg::ADDR_W-1:0] room_ff, room_in;
   logic [tsbr_pkg::RANK_W-1:0] rank_ff, rank_in;
   logic                        err_ff, err_in;
   logic                        valid_ff, valid_in;
   tsbr_pkg::rsp_type           part_ff, part_in;
   logic                        fit;
   logic [tsbr_pkg::ADDR_W-1:0] size;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsbr_pkg::BACK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      loc_ff    <= loc_in;
      base_ff   <= base_in;
      slice_ff  <= slice_in;
      amount_ff <= amount_in;
      within_ff <= within_in;
      room_ff   <= room_in;
      rank_ff   <= rank_in;
      err_ff    <= err_in;
      part_ff   <= part_in;
   end

   assign fit  = (amount_ff <= room_ff);
   assign size = fit ? amount_ff : room_ff;

   always_comb begin
      state_in  = state_ff;
      loc_in    = loc_ff;
      base_in   = base_ff;
      slice_in  = slice_ff;
      amount_in = amount_ff;
      within_in = within_ff;
      room_in   = room_ff;
      rank_in   = rank_ff;
      err_in    = err_ff;
      valid_in  = 1'b0;
      part_in   = part_ff;
      q_pop     = 1'b0;

      case (state_ff)
         tsbr_pkg::BACK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop     = 1'b1;
               loc_in    = {1'b0, q_job.loc};
               base_in   = q_job.base;
               slice_in  = q_job.slice;
               amount_in = q_job.amount;
               within_in = q_job.slice_ofs;
               room_in   = q_job.slice - q_job.slice_ofs;
               rank_in   = q_job.rank;
               err_in    = q_job.err;
               state_in  = tsbr_pkg::BACK_RUN;
            end
         end
         tsbr_pkg::BACK_RUN: begin
            valid_in = 1'b1;
            if (err_ff) begin
               part_in.part_local_offset  = loc_ff;
               part_in.part_rank          = '0;
               part_in.part_size          = '0;
               part_in.part_remote_offset = '0;
               part_in.part_last          = 1'b1;
               part_in.part_error         = 1'b1;
               state_in                   = tsbr_pkg::BACK_IDLE;
            end else begin
               part_in.part_local_offset  = loc_ff;
               part_in.part_rank          = rank_ff;
               part_in.part_size          = size;
               part_in.part_remote_offset = {1'b0, base_ff} + {1'b0, within_ff};
               part_in.part_last          = fit;
               part_in.part_error         = 1'b0;
               amount_in = amount_ff - size;
               loc_in    = loc_ff + {1'b0, size};
               rank_in   = rank_ff + tsbr_pkg::RANK_W'(1);
               within_in = '0;
               room_in   = slice_ff;
               if (fit) begin
                  state_in = tsbr_pkg::BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = tsbr_pkg::BACK_IDLE;
         end
      endcase
   end

   assign rsp_valid = valid_ff;
   assign rsp_part  = part_ff;

endmodule

FILE: src/transfer_split_by_rank.sv
// Top level of the transfer splitter: front end, job queue, back end.
// Depends on tsbr_pkg, tsbr_front, tsbr_queue, tsbr_back.
//
//   channel   ports                       handshake
//   request   start, busy, req_item       accepted when start && !busy
//   result    rsp_valid, rsp_part         one-cycle strobe, cannot stall
//
// A request occupies the front end through a span check, a 6-step
// restoring division for the first rank and a queue write; error requests
// skip the division; zero-byte requests leave after the span check with no
// result. The back end emits one part per cycle after loading a job from
// the queue; a request yields up to MAX_RANKS parts.
// busy rises only while the front end holds a transaction; with the queue
// full the front end waits in its queue-write step.
// Reset (synchronous) empties the queue and returns both ends to idle.
module transfer_split_by_rank #(
   parameter int MAX_RANKS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tsbr_pkg::req_type req_item,
   output logic              rsp_valid,
   output tsbr_pkg::rsp_type rsp_part
);

   tsbr_pkg::qstat_type q_stat;
   tsbr_pkg::job_type   wr_job, rd_job;
   logic                q_push, q_pop;

   tsbr_front #(
      .MAX_RANKS(MAX_RANKS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_job    (wr_job)
   );

   tsbr_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_job (wr_job),
      .pop    (q_pop),
      .rd_job (rd_job),
      .stat   (q_stat)
   );

   tsbr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_job     (rd_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_part  (rsp_part)
   );

endmodule

FILE: src/tsbr_checker.sv
// Port-level checks for the transfer splitter, bound to the top level.
// Depends on tsbr_pkg and transfer_split_by_rank.
module tsbr_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input tsbr_pkg::rsp_type rsp_part
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after accepted transaction");

   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_part.part_error |->
         rsp_part.part_last && rsp_part.part_size == '0 &&
         rsp_part.part_rank == '0 && rsp_part.part_remote_offset == '0)
      else $error("malformed error part");

   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_part.part_error |-> rsp_part.part_size != '0)
      else $error("empty data part");

   a_rank_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_part.part_last |=>
         rsp_valid && !rsp_part.part_error &&
         rsp_part.part_rank == $past(rsp_part.part_rank) + 6'd1)
      else $error("parts of one transaction not back to back");

endmodule

bind transfer_split_by_rank tsbr_checker u_tsbr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_part  (rsp_part)
);

FILE: tb/sv/testbench.sv
// Testbench for transfer_split_by_rank: drives split requests and checks every
// emitted part against a built-in prediction kept by a scoreboard class.
// Depends on tsbr_pkg and the transfer_split_by_rank RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_RANKS = 64;
   localparam logic [63:0] MAX48 = 64'h0000_FFFF_FFFF_FFFF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_ITEMS = 410;

   class split_checker;
      tsbr_pkg::rsp_type expected_parts[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      function int pending();
         return expected_parts.size();
      endfunction

      function void note_request(tsbr_pkg::req_type r);
         logic [63:0] loc, base, off, slice, amount, rank, slice_ofs, room, size;
         tsbr_pkg::rsp_type p;
         int          n;
         loc    = 64'(r.local_start);
         base   = 64'(r.peer_base);
         off    = 64'(r.global_offset);
         slice  = 64'(r.slice_size);
         amount = 64'(r.byte_count);
         n      = 0;
         if (amount == 0) return;
         if (slice == 0 || (off + amount - 1) / slice >= MAX_RANKS) begin
            p = '0;
            p.part_local_offset = loc[tsbr_pkg::WIDE_W-1:0];
            p.part_last = 1'b1;
            p.part_error = 1'b1;
            expected_parts.push_back(p);
            return;
         end
         while (amount != 0 && n < MAX_RANKS) begin
            rank      = off / slice;
            slice_ofs = off % slice;
            room      = slice - slice_ofs;
            size      = (amount < room) ? amount : room;
            amount    = amount - size;
            p.part_local_offset  = loc[tsbr_pkg::WIDE_W-1:0];
            p.part_rank          = rank[tsbr_pkg::RANK_W-1:0];
            p.part_size          = size[tsbr_pkg::ADDR_W-1:0];
            p.part_remote_offset = tsbr_pkg::WIDE_W'(base + slice_ofs);
            p.part_last          = (amount == 0);
            p.part_error         = 1'b0;
            expected_parts.push_back(p);
            n++;
            loc = loc + size;
            off = off + size;
         end
      endfunction

      function void check_part(tsbr_pkg::rsp_type got);
         tsbr_pkg::rsp_type want;
         if (expected_parts.size() == 0) begin
            $error("unexpected part: local 0x%0h rank %0d size 0x%0h",
                   got.part_local_offset, got.part_rank, got.part_size);
            errors++;
            return;
         end
         want = expected_parts.pop_front();
         if (got.part_local_offset !== want.part_local_offset) begin
            $error("part_local_offset: expected 0x%0h, actual 0x%0h",
                   want.part_local_offset, got.part_local_offset);
            errors++;
         end
         if (got.part_rank !== want.part_rank) begin
            $error("part_rank: expected %0d, actual %0d", want.part_rank, got.part_rank);
            errors++;
         end
         if (got.part_size !== want.part_size) begin
            $error("part_size: expected 0x%0h, actual 0x%0h", want.part_size, got.part_size);
            errors++;
         end
         if (got.part_remote_offset !== want.part_remote_offset) begin
            $error("part_remote_offset: expected 0x%0h, actual 0x%0h",
                   want.part_remote_offset, got.part_remote_offset);
            errors++;
         end
         if (got.part_last !== want.part_last) begin
            $error("part_last: expected %0d, actual %0d", want.part_last, got.part_last);
            errors++;
         end
         if (got.part_error !== want.part_error) begin
            $error("part_error: expected %0d, actual %0d", want.part_error, got.part_error);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   tsbr_pkg::req_type req_item;
   logic    rsp_valid;
   tsbr_pkg::rsp_type rsp_part;

   split_checker sb = new();
   int idle_cycles = 0;

   transfer_split_by_rank #(.MAX_RANKS(MAX_RANKS)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_part (rsp_part)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_item);
         if (rsp_valid) sb.check_part(rsp_part);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_below(logic [63:0] n);
      return rand64() % n;
   endfunction

   function automatic logic [63:0] rand_bits(int w);
      return rand64() & ((64'd1 << w) - 1);
   endfunction

   function automatic tsbr_pkg::req_type mk_req(logic [63:0] loc, logic [63:0] base,
                                                logic [63:0] off, logic [63:0] slice,
                                                logic [63:0] amount);
      tsbr_pkg::req_type r;
      r.local_start   = loc[tsbr_pkg::ADDR_W-1:0];
      r.peer_base     = base[tsbr_pkg::ADDR_W-1:0];
      r.global_offset = off[tsbr_pkg::ADDR_W-1:0];
      r.slice_size    = slice[tsbr_pkg::ADDR_W-1:0];
      r.byte_count    = amount[tsbr_pkg::ADDR_W-1:0];
      return r;
   endfunction

   // Valid request spanning a few ranks, occasionally every rank that fits.
   function automatic tsbr_pkg::req_type wellformed_req();
      logic [63:0] slice, hi_rank, nr, r0, w0, lo, off, last, amount;
      slice = rand_bits($urandom_range(1, 48));
      if (slice == 0) slice = 1;
      hi_rank = MAX48 / slice;
      if (hi_rank > MAX_RANKS - 1) hi_rank = MAX_RANKS - 1;
      nr = ($urandom_range(0, 99) < 5) ? hi_rank + 1 : 64'($urandom_range(1, 4));
      if (nr > hi_rank + 1) nr = hi_rank + 1;
      r0 = rand_below(hi_rank + 2 - nr);
      w0 = rand_below(slice);
      off = r0 * slice + w0;
      if (off > MAX48) off = MAX48;
      lo = (nr == 1) ? w0 : 0;
      last = (r0 + nr - 1) * slice + lo + rand_below(slice - lo);
      if (last > MAX48) last = MAX48;
      if (last < off) last = off;
      amount = last - off + 1;
      if (amount > MAX48) amount = MAX48;
      return mk_req(rand64(), rand64(), off, slice, amount);
   endfunction

   function automatic tsbr_pkg::req_type random_req();
      logic [63:0] slice, off, last;
      int          p;
      p = $urandom_range(0, 99);
      if (p < 8) begin
         return mk_req(rand64(), rand64(), rand64(),
                       ($urandom_range(0, 1) == 0) ? 64'd0 : rand_bits($urandom_range(1, 48)),
                       64'd0);
      end else if (p < 16) begin
         return mk_req(rand64(), rand64(), rand64(), 64'd0,
                       rand_bits($urandom_range(1, 48)) | 64'd1);
      end else if (p < 24) begin
         slice = rand_bits($urandom_range(1, 20)) | 64'd1;
         off = rand_below(MAX_RANKS * slice);
         last = MAX_RANKS * slice + rand_below(slice * 30);
         return mk_req(rand64(), rand64(), off, slice, last - off + 1);
      end else if (p < 32) begin
         return mk_req(rand64(), rand64(), rand64(), rand64(), rand64());
      end
      return wellformed_req();
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Called at a falling edge; returns at a falling edge.
   task automatic send_request(tsbr_pkg::req_type r, int gap);
      req_item = r;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send_request(mk_req(0, 0, 0, 0, 0), pick_gap());
      send_request(mk_req(5, 7, 100, 16, 0), pick_gap());
      send_request(mk_req(123, 456, 789, 0, 1), pick_gap());
      send_request(mk_req(MAX48, MAX48, 0, 0, MAX48), pick_gap());
      send_request(mk_req(0, 0, 0, 16, 1024), pick_gap());
      send_request(mk_req(0, 0, 0, 16, 1025), pick_gap());
      send_request(mk_req(1, 2, 63, 1, 1), pick_gap());
      send_request(mk_req(3, 4, 64, 1, 1), pick_gap());
      send_request(mk_req(0, 0, 0, 1, 64), pick_gap());
      send_request(mk_req(MAX48, MAX48, MAX48, MAX48, MAX48), pick_gap());
      send_request(mk_req(MAX48, MAX48, MAX48 - 1, MAX48, 2), pick_gap());
      send_request(mk_req(10, 20, 30, 100, 70), pick_gap());
      send_request(mk_req(10, 20, 30, 100, 71), pick_gap());
      send_request(mk_req(0, 1000, 250, 100, 500), pick_gap());
      send_request(mk_req(0, 0, 0, MAX48, MAX48), pick_gap());
      send_request(mk_req(7, 0, 63 * 1000 + 999, 1000, 1), pick_gap());
      send_request(mk_req(7, 0, 63 * 1000 + 999, 1000, 2), pick_gap());
      send_request(mk_req(0, 0, 0, 1, MAX48), pick_gap());
      send_request(mk_req(0, 0, MAX48, 1, 1), pick_gap());
      send_request(mk_req(64'd1 << 47, 64'd1 << 47, 64'd1 << 47, 64'd1 << 47,
                          64'd1 << 47), pick_gap());
      wait_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) wait_drained();
         send_request(random_req(), ((i % 60) < 15) ? 0 : pick_gap());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
